>>> src/dwit_pkg.sv
// dwit_pkg: item types and operation codes for the display window table
// no dependencies; imported by every module of the block

package dwit_pkg;

  localparam int START_W     = 3;
  localparam int SPAN_W      = 4;
  localparam int SUM_W       = 5;  // holds start + span without overflow
  localparam int MAP_W       = 8;
  localparam int COUNT_OUT_W = 3;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [START_W-1:0] start_digit;
    logic [SPAN_W-1:0]  span;
  } dwit_in_t;

  typedef struct packed {
    logic                   accepted;
    logic [COUNT_OUT_W-1:0] window_count;
    logic [MAP_W-1:0]       start_map;
    logic [MAP_W-1:0]       cover_map;
  } dwit_out_t;

  // status of one table operation, handed from the table to the top level
  typedef struct packed {
    logic                   accepted;
    logic [COUNT_OUT_W-1:0] window_count;
  } dwit_stat_t;

endpackage

>>> src/dwit_table.sv
// dwit_table: sorted window slots with insert, clear and remove operations
// depends on dwit_pkg; exposes the next table contents for the summary logic

module dwit_table
  import dwit_pkg::*;
#(
  parameter int SLOTS  = 4,
  parameter int DIGITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  dwit_in_t           op_i,
  output logic [START_W-1:0] start_d_o [SLOTS],
  output logic [SPAN_W-1:0]  span_d_o  [SLOTS],
  output logic [SLOTS-1:0]   valid_d_o,
  output dwit_stat_t         stat_o
);

  localparam int CW = $clog2(SLOTS + 1);

  logic [START_W-1:0] start_q [SLOTS];
  logic [SPAN_W-1:0]  span_q  [SLOTS];
  logic [SLOTS-1:0]   valid_q;
  logic [CW-1:0]      count_q;

  logic [START_W-1:0] start_d [SLOTS];
  logic [SPAN_W-1:0]  span_d  [SLOTS];
  logic [SLOTS-1:0]   valid_d;
  logic [CW-1:0]      count_d;

  logic [CW-1:0]    pos;
  logic             hit;
  logic             overlap;
  logic             ins_ok;
  logic             ok;
  logic [SUM_W-1:0] s_ext;
  logic [SUM_W-1:0] s_end;

  assign s_ext = SUM_W'(op_i.start_digit);
  assign s_end = s_ext + SUM_W'(op_i.span);

  always_comb begin
    pos     = '0;
    hit     = 1'b0;
    overlap = 1'b0;
    // slots are sorted, so the insert place and the remove index are both
    // the number of active windows starting below the requested digit
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_q[i]) begin
        if (start_q[i] < op_i.start_digit) begin
          pos = pos + 1'b1;
        end
        if (start_q[i] == op_i.start_digit) begin
          hit = 1'b1;
        end
        if ((s_ext < SUM_W'(start_q[i]) + SUM_W'(span_q[i])) &&
            (SUM_W'(start_q[i]) < s_end)) begin
          overlap = 1'b1;
        end
      end
    end
    ins_ok = (count_q != CW'(SLOTS)) && (op_i.span != '0) &&
             (s_ext < SUM_W'(DIGITS)) && (s_end <= SUM_W'(DIGITS)) && !overlap;
  end

  always_comb begin
    start_d = start_q;
    span_d  = span_q;
    valid_d = valid_q;
    count_d = count_q;
    ok      = 1'b0;
    case (op_i.mode)
      MODE_INSERT: begin
        if (ins_ok) begin
          ok      = 1'b1;
          count_d = count_q + 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            if (CW'(i) == pos) begin
              start_d[i] = op_i.start_digit;
              span_d[i]  = op_i.span;
              valid_d[i] = 1'b1;
            end else if (CW'(i) > pos) begin
              if (i > 0) begin
                start_d[i] = start_q[i-1];
                span_d[i]  = span_q[i-1];
                valid_d[i] = valid_q[i-1];
              end
            end
          end
        end
      end
      MODE_CLEAR: begin
        ok      = 1'b1;
        count_d = '0;
        valid_d = '0;
        for (int i = 0; i < SLOTS; i++) begin
          start_d[i] = '0;
          span_d[i]  = '0;
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          ok      = 1'b1;
          count_d = count_q - 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            if (CW'(i) >= pos) begin
              if (i + 1 < SLOTS) begin
                start_d[i] = start_q[i+1];
                span_d[i]  = span_q[i+1];
                valid_d[i] = valid_q[i+1];
              end else begin
                start_d[i] = '0;
                span_d[i]  = '0;
                valid_d[i] = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        start_q[i] <= '0;
        span_q[i]  <= '0;
      end
    end else if (en_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
      start_q <= start_d;
      span_q  <= span_d;
    end
  end

  assign start_d_o           = start_d;
  assign span_d_o            = span_d;
  assign valid_d_o           = valid_d;
  assign stat_o.accepted     = ok;
  assign stat_o.window_count = COUNT_OUT_W'(count_d);

endmodule

>>> src/dwit_maps.sv
// dwit_maps: start and coverage bitmaps of the active windows
// depends on dwit_pkg; fed by the next table contents from dwit_table

module dwit_maps
  import dwit_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  logic [START_W-1:0] start_i [SLOTS],
  input  logic [SPAN_W-1:0]  span_i  [SLOTS],
  input  logic [SLOTS-1:0]   valid_i,
  output logic [MAP_W-1:0]   start_map_o,
  output logic [MAP_W-1:0]   cover_map_o
);

  always_comb begin
    start_map_o = '0;
    cover_map_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_i[i]) begin
        start_map_o[start_i[i]] = 1'b1;
        for (int d = 0; d < MAP_W; d++) begin
          // digits past the map width are simply not shown
          if ((SUM_W'(d) >= SUM_W'(start_i[i])) &&
              (SUM_W'(d) < SUM_W'(start_i[i]) + SUM_W'(span_i[i]))) begin
            cover_map_o[d] = 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> src/display_window_interval_table.sv
// Window table for a multi-digit display: keeps up to SLOTS non-overlapping
// digit windows sorted by start and answers each insert, clear or remove item
// with acceptance, the window count and start and coverage bitmaps. An item
// enters an input register; when the result register is empty or being drained,
// the table update and the bitmap summary are done from it and land in the result
// register, and one item is taken every cycle while the result is not stalled.
// A held result stalls the input only once the input register is also full.
// depends on dwit_pkg, dwit_table and dwit_maps

module display_window_interval_table
  import dwit_pkg::*;
#(
  parameter int SLOTS  = 4,
  parameter int DIGITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dwit_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dwit_out_t out_data_o
);

  logic      in_full_q;
  dwit_in_t  in_q;
  logic      out_valid_q;
  dwit_out_t out_q;

  logic      in_take;
  logic      advance;

  logic [START_W-1:0] start_d [SLOTS];
  logic [SPAN_W-1:0]  span_d  [SLOTS];
  logic [SLOTS-1:0]   valid_d;
  dwit_stat_t         stat;
  logic [MAP_W-1:0]   start_map;
  logic [MAP_W-1:0]   cover_map;

  // held item moves on when the result register is empty or being drained
  assign advance    = in_full_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  dwit_table #(
    .SLOTS  (SLOTS),
    .DIGITS (DIGITS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .op_i      (in_q),
    .start_d_o (start_d),
    .span_d_o  (span_d),
    .valid_d_o (valid_d),
    .stat_o    (stat)
  );

  dwit_maps #(
    .SLOTS (SLOTS)
  ) u_maps (
    .start_i     (start_d),
    .span_i      (span_d),
    .valid_i     (valid_d),
    .start_map_o (start_map),
    .cover_map_o (cover_map)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.accepted     <= stat.accepted;
      out_q.window_count <= stat.window_count;
      out_q.start_map    <= start_map;
      out_q.cover_map    <= cover_map;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/dwit_checker.sv
// dwit_checker: port-level checks of the display window table over time
// depends on dwit_pkg; bound to display_window_interval_table below

module dwit_checker
  import dwit_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input dwit_out_t out_data_o
);

  // every window start is a covered digit
  a_start_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.start_map & ~out_data_o.cover_map) == '0))
    else $error("window start outside cover map");

  // one start bit per active window
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((SLOTS >= 8) ||
      ($countones(out_data_o.start_map) == int'(out_data_o.window_count))))
    else $error("window count differs from start map");

  // the input only stalls while a finished result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with free result register");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // the result register stays full while an item waits at a stalled input
  a_in_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (out_valid_o))
    else $error("result register emptied under input stall");

endmodule

bind display_window_interval_table dwit_checker #(.SLOTS(SLOTS)) u_dwit_checker (.*);

>>> tb/display_window_interval_table_tb.sv
// display_window_interval_table_tb: self-checking bench for the digit window table
// directed rows then random operations, each result checked against its typed row or a local model
// depends on dwit_pkg and display_window_interval_table
`timescale 1ns / 100ps

module display_window_interval_table_tb;
  import dwit_pkg::*;

  localparam int NUM_SLOTS   = 4;
  localparam int NUM_DIGITS  = 8;
  localparam int RAND_ITEMS  = 600;
  localparam int QUIET_FIRST = 250;
  localparam int QUIET_LAST  = 400;
  localparam int IDLE_PCT    = 7;
  localparam int DRAIN_CYC   = 8;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    dwit_in_t  op;
    bit        typed;
    dwit_out_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  dwit_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  dwit_out_t out_data_o;

  display_window_interval_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // local copy of the window table
  logic [START_W-1:0] win_start [NUM_SLOTS];
  logic [SPAN_W-1:0]  win_span  [NUM_SLOTS];
  bit                 win_valid [NUM_SLOTS];
  int                 win_count;

  dir_row_t  dir_rows [$];
  dwit_out_t pending_results [$];
  int        taken     = 0;
  int        cur_row   = -1;
  int        fail_cnt  = 0;
  bit        stim_done = 1'b0;

  function automatic void clear_windows();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      win_start[i] = '0;
      win_span[i]  = '0;
      win_valid[i] = 1'b0;
    end
    win_count = 0;
  endfunction

  function automatic int used_windows();
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) if (win_valid[i]) n++;
    return n;
  endfunction

  function automatic bit insert_window(int s, int n);
    int cnt;
    int pos;
    cnt = used_windows();
    if (cnt >= NUM_SLOTS || n == 0 || s >= NUM_DIGITS || s + n > NUM_DIGITS) return 1'b0;
    for (int i = 0; i < cnt; i++) begin
      if (s < win_start[i] + win_span[i] && win_start[i] < s + n) return 1'b0;
    end
    pos = 0;
    while (pos < cnt && win_start[pos] < s) pos++;
    for (int i = cnt; i > pos; i--) begin
      win_start[i] = win_start[i-1];
      win_span[i]  = win_span[i-1];
      win_valid[i] = win_valid[i-1];
    end
    win_start[pos] = s[START_W-1:0];
    win_span[pos]  = n[SPAN_W-1:0];
    win_valid[pos] = 1'b1;
    win_count = cnt + 1;
    return 1'b1;
  endfunction

  function automatic bit remove_window(int s);
    int cnt;
    int k;
    cnt = used_windows();
    k = 0;
    while (k < cnt && win_start[k] != s) k++;
    if (k >= cnt) return 1'b0;
    for (int i = k; i + 1 < cnt; i++) begin
      win_start[i] = win_start[i+1];
      win_span[i]  = win_span[i+1];
      win_valid[i] = win_valid[i+1];
    end
    win_start[cnt-1] = '0;
    win_span[cnt-1]  = '0;
    win_valid[cnt-1] = 1'b0;
    win_count = cnt - 1;
    return 1'b1;
  endfunction

  // applies one operation to the local table and returns the summary after it
  function automatic dwit_out_t apply_window_op(dwit_in_t op);
    dwit_out_t res;
    res = '0;
    case (op.mode)
      MODE_INSERT: res.accepted = insert_window(op.start_digit, op.span);
      MODE_CLEAR: begin
        clear_windows();
        res.accepted = 1'b1;
      end
      MODE_REMOVE: res.accepted = remove_window(op.start_digit);
      default:     res.accepted = 1'b0;
    endcase
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (win_valid[i]) begin
        res.start_map[win_start[i]] = 1'b1;
        for (int d = win_start[i]; d < win_start[i] + win_span[i]; d++)
          if (d < MAP_W) res.cover_map[d] = 1'b1;
      end
    end
    res.window_count = win_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  // mostly well-formed inserts and removes of live windows, some noise
  function automatic dwit_in_t random_op();
    dwit_in_t op;
    int       r;
    op.mode        = MODE_INSERT;
    op.start_digit = START_W'($urandom_range(0, NUM_DIGITS - 1));
    op.span        = SPAN_W'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 62) begin
      if ($urandom_range(0, 99) < 85)
        op.span = SPAN_W'($urandom_range(1, NUM_DIGITS - op.start_digit));
    end else if (r < 90) begin
      op.mode = MODE_REMOVE;
      if (win_count > 0 && $urandom_range(0, 99) < 70)
        op.start_digit = win_start[$urandom_range(0, win_count - 1)];
    end else if (r < 96) begin
      op.mode = MODE_CLEAR;
    end else begin
      op.mode = MODE_UNUSED;
    end
    return op;
  endfunction

  function automatic void add_row(logic [1:0] m, int s, int n, bit typed = 1'b0,
                                  bit acc = 1'b0, int cnt = 0, int smap = 0, int cmap = 0);
    dir_row_t row;
    row.op.mode        = m;
    row.op.start_digit = s[START_W-1:0];
    row.op.span        = n[SPAN_W-1:0];
    row.typed          = typed;
    row.want.accepted     = acc;
    row.want.window_count = cnt[COUNT_OUT_W-1:0];
    row.want.start_map    = smap[MAP_W-1:0];
    row.want.cover_map    = cmap[MAP_W-1:0];
    dir_rows.push_back(row);
  endfunction

  initial begin
    clear_windows();
    add_row(MODE_REMOVE, 0, 0, 1, 0, 0, 'h00, 'h00);  // remove from empty table
    add_row(MODE_INSERT, 0, 0, 1, 0, 0, 'h00, 'h00);  // zero span
    add_row(MODE_INSERT, 0, 8, 1, 1, 1, 'h01, 'hFF);  // whole display
    add_row(MODE_INSERT, 3, 1, 1, 0, 1, 'h01, 'hFF);  // overlap
    add_row(MODE_INSERT, 0, 8);                       // same start
    add_row(MODE_CLEAR,  0, 0, 1, 1, 0, 'h00, 'h00);
    add_row(MODE_INSERT, 7, 1, 1, 1, 1, 'h80, 'h80);  // last digit
    add_row(MODE_INSERT, 7, 2);
    add_row(MODE_INSERT, 5, 4);                       // runs past the end
    add_row(MODE_INSERT, 2, 15);
    add_row(MODE_INSERT, 0, 2);
    add_row(MODE_INSERT, 3, 3);
    add_row(MODE_INSERT, 2, 1);                       // fills the table
    add_row(MODE_INSERT, 6, 1);                       // table full
    add_row(MODE_REMOVE, 3, 0);                       // middle slot, later ones shift
    add_row(MODE_INSERT, 4, 2);
    add_row(MODE_REMOVE, 5, 0);                       // inside a window, not a start
    add_row(MODE_UNUSED, 7, 15);
    add_row(MODE_REMOVE, 0, 0);
    add_row(MODE_REMOVE, 7, 0);
    add_row(MODE_REMOVE, 2, 0);
    add_row(MODE_REMOVE, 4, 0);
    add_row(MODE_INSERT, 1, 9);
    add_row(MODE_CLEAR,  0, 0, 1, 1, 0, 'h00, 'h00);  // clear on empty table
  end

  function automatic bit quiet_stretch();
    return taken >= dir_rows.size() + QUIET_FIRST && taken < dir_rows.size() + QUIET_LAST;
  endfunction

  // item source: hold each item until taken, then pick the next or idle
  always @(posedge clk_i) begin
    dwit_out_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        res = apply_window_op(in_data_i);
        if (cur_row >= 0 && dir_rows[cur_row].typed) res = dir_rows[cur_row].want;
        pending_results.push_back(res);
        taken++;
        if (taken == dir_rows.size() + RAND_ITEMS) stim_done = 1'b1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (stim_done || (!quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT)) begin
          in_valid_i <= 1'b0;
        end else if (taken < dir_rows.size()) begin
          cur_row = taken;
          in_valid_i <= 1'b1;
          in_data_i  <= dir_rows[taken].op;
        end else begin
          cur_row = -1;
          in_valid_i <= 1'b1;
          in_data_i  <= random_op();
        end
      end
      out_stall_i <= !quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT;
    end
  end

  always @(posedge clk_i) begin
    dwit_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: %h", out_data_o);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data_o.accepted);
          fail_cnt++;
        end
        if (out_data_o.window_count !== want.window_count) begin
          $error("window_count: expected %0d, got %0d", want.window_count,
                 out_data_o.window_count);
          fail_cnt++;
        end
        if (out_data_o.start_map !== want.start_map) begin
          $error("start_map: expected %b, got %b", want.start_map, out_data_o.start_map);
          fail_cnt++;
        end
        if (out_data_o.cover_map !== want.cover_map) begin
          $error("cover_map: expected %b, got %b", want.cover_map, out_data_o.cover_map);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!stim_done) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("display_window_interval_table_tb: PASS");
    end else begin
      $display("display_window_interval_table_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("display_window_interval_table_tb: FAIL");
    $finish;
  end

endmodule
